@@ rtl/ttodc_pkg.sv @@
// Package for the tick time-of-day clock: limits, widths, the per-beat result struct
// and the ASCII digit helper. No dependencies.

package ttodc_pkg;

   localparam int unsigned TICKS_PER_SECOND = 1024;   // range 2..1024
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned MINUTES_PER_HOUR = 60;
   localparam int unsigned HOURS_PER_DAY = 24;

   localparam int unsigned TICK_WIDTH = 10;
   localparam int unsigned SECOND_WIDTH = 6;
   localparam int unsigned MINUTE_WIDTH = 6;
   localparam int unsigned HOUR_WIDTH = 5;
   localparam int unsigned SLICE_WIDTH = 16;
   localparam int unsigned TEXT_WIDTH = 48;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   // Input beat kinds, carried on req_tuser
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   // Numeric result of one beat, passed from the time keeper to the output stage
   typedef struct packed {
      logic [HOUR_WIDTH-1:0]   hours;
      logic [MINUTE_WIDTH-1:0] minutes;
      logic [SECOND_WIDTH-1:0] seconds;
      logic [TICK_WIDTH-1:0]   subsecond;
      logic                    second_rolled;
      logic                    switch_request;
   } time_result_type;

   // Two ASCII digits of a value below 64; tens by multiply with 205 and shift by 11
   function automatic logic [15:0] two_digits(input logic [5:0] value);
      logic [13:0] product;
      logic [2:0]  tens;
      logic [5:0]  ones;
      product = 14'(value) * 14'd205;
      tens = product[13:11];
      ones = value - 6'(6'(tens) * 6'd10);
      return {ASCII_ZERO | {5'd0, tens}, ASCII_ZERO | {2'd0, ones[3:0]}};
   endfunction

endpackage

@@ rtl/ttodc_time.sv @@
// Time keeper: prescaler, seconds, minutes, hours and the slice countdown.
// Uses ttodc_pkg; state advances on each beat handed to the output stage.

module ttodc_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  ttodc_pkg::kind_type                 kind,
   input  logic [ttodc_pkg::SLICE_WIDTH-1:0]   slice_count,
   output ttodc_pkg::time_result_type          result
);

   logic [ttodc_pkg::TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic [ttodc_pkg::SECOND_WIDTH-1:0] second_ff, second_in;
   logic [ttodc_pkg::MINUTE_WIDTH-1:0] minute_ff, minute_in;
   logic [ttodc_pkg::HOUR_WIDTH-1:0]   hour_ff, hour_in;
   logic [ttodc_pkg::SLICE_WIDTH-1:0]  slice_ff, slice_in;
   logic                               armed_ff, armed_in;

   logic [ttodc_pkg::TICK_WIDTH:0]     tick_sum;
   logic [ttodc_pkg::SECOND_WIDTH:0]   second_sum;
   logic [ttodc_pkg::MINUTE_WIDTH:0]   minute_sum;
   logic [ttodc_pkg::HOUR_WIDTH:0]     hour_sum;
   logic                               rolled;
   logic                               request;

   assign tick_sum   = {1'b0, tick_ff} + 1'b1;
   assign second_sum = {1'b0, second_ff} + 1'b1;
   assign minute_sum = {1'b0, minute_ff} + 1'b1;
   assign hour_sum   = {1'b0, hour_ff} + 1'b1;

   always_comb begin
      tick_in   = tick_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      slice_in  = slice_ff;
      armed_in  = armed_ff;
      rolled    = 1'b0;
      request   = 1'b0;
      unique case (kind)
         ttodc_pkg::KIND_LOAD: begin
            slice_in = slice_count;
            armed_in = 1'b1;
         end
         ttodc_pkg::KIND_TICK: begin
            if (tick_sum >= (ttodc_pkg::TICK_WIDTH + 1)'(ttodc_pkg::TICKS_PER_SECOND)) begin
               tick_in = '0;
               rolled  = 1'b1;
               if (second_sum >=
                     (ttodc_pkg::SECOND_WIDTH + 1)'(ttodc_pkg::SECONDS_PER_MINUTE)) begin
                  second_in = '0;
                  if (minute_sum >=
                        (ttodc_pkg::MINUTE_WIDTH + 1)'(ttodc_pkg::MINUTES_PER_HOUR)) begin
                     minute_in = '0;
                     if (hour_sum >= (ttodc_pkg::HOUR_WIDTH + 1)'(ttodc_pkg::HOURS_PER_DAY))
                        hour_in = '0;
                     else
                        hour_in = hour_sum[ttodc_pkg::HOUR_WIDTH-1:0];
                  end else begin
                     minute_in = minute_sum[ttodc_pkg::MINUTE_WIDTH-1:0];
                  end
               end else begin
                  second_in = second_sum[ttodc_pkg::SECOND_WIDTH-1:0];
               end
            end else begin
               tick_in = tick_sum[ttodc_pkg::TICK_WIDTH-1:0];
            end
            // count down while armed; hold at zero and keep requesting
            if (armed_ff) begin
               if (slice_ff != '0)
                  slice_in = slice_ff - 1'b1;
               else
                  request = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign result.hours          = hour_in;
   assign result.minutes        = minute_in;
   assign result.seconds        = second_in;
   assign result.subsecond      = tick_in;
   assign result.second_rolled  = rolled;
   assign result.switch_request = request;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         second_ff <= '0;
         minute_ff <= '0;
         hour_ff   <= '0;
         slice_ff  <= '0;
         armed_ff  <= 1'b0;
      end else if (step_en) begin
         tick_ff   <= tick_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
         slice_ff  <= slice_in;
         armed_ff  <= armed_in;
      end
   end

`ifndef SYNTHESIS
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff < ttodc_pkg::HOUR_WIDTH'(ttodc_pkg::HOURS_PER_DAY))
      else $error("hour counter out of range");

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      step_en && kind == ttodc_pkg::KIND_LOAD |=> armed_ff && slice_ff == $past(slice_count))
      else $error("load beat did not arm the countdown");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      kind == ttodc_pkg::KIND_LOAD |-> !result.second_rolled && !result.switch_request)
      else $error("load beat raised a flag");

   a_request_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && result.switch_request |=> armed_ff && slice_ff == '0)
      else $error("countdown left zero after a switch request");

   a_roll_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && result.second_rolled |=> tick_ff == '0)
      else $error("prescaler not cleared on second rollover");
`endif

endmodule

@@ rtl/ttodc_digits.sv @@
// Display formatter: turns hours, minutes and seconds into six ASCII digits HHMMSS.
// Uses ttodc_pkg::two_digits.

module ttodc_digits (
   input  logic [ttodc_pkg::HOUR_WIDTH-1:0]   hours,
   input  logic [ttodc_pkg::MINUTE_WIDTH-1:0] minutes,
   input  logic [ttodc_pkg::SECOND_WIDTH-1:0] seconds,
   output logic [ttodc_pkg::TEXT_WIDTH-1:0]   time_text
);

   // first hour digit lands in the top byte
   assign time_text = {ttodc_pkg::two_digits({1'b0, hours}),
                       ttodc_pkg::two_digits(minutes),
                       ttodc_pkg::two_digits(seconds)};

endmodule

@@ rtl/tick_time_of_day_clock_core.sv @@
// Top level of the tick time-of-day clock: input register, time keeper, formatter
// and result register. Depends on ttodc_pkg, ttodc_time and ttodc_digits.
//
//   channel   direction  tdata                               tuser
//   req_      in         slice_count[15:0]                   kind (0 tick, 1 load slice)
//   rsp_      out        hours..switch_request, 80 bits      -
//
// One beat per cycle sustained while rsp_tready stays high; a beat reaches rsp_ through
// the input register, then the result register, and the carry chain of the prescaler
// and time counters lies between the two.
// Reset clears both stage valids, the time to 00:00:00 and disarms switching.
// A stall on rsp_ holds the result register and the input register; req_tready
// drops only when both are full and rsp_tready is low.

module tick_time_of_day_clock_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] slice_count
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] hours, [10:5] minutes, [16:11] seconds, [26:17] subsecond,
   // [74:27] time_text, [75] second_rolled, [76] switch_request, [79:77] zero
   output logic [79:0] rsp_tdata
);

   // input register
   logic                                in_valid_ff, in_valid_in;
   ttodc_pkg::kind_type                 in_kind_ff;
   logic [ttodc_pkg::SLICE_WIDTH-1:0]   in_slice_ff;

   // result register
   logic                                out_valid_ff, out_valid_in;
   logic [79:0]                         out_data_ff, out_data_in;

   logic                                out_free;
   logic                                step_en;
   ttodc_pkg::time_result_type          result;
   logic [ttodc_pkg::TEXT_WIDTH-1:0]    time_text;

   // result register can take a beat when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   ttodc_time u_time (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .kind        (in_kind_ff),
      .slice_count (in_slice_ff),
      .result      (result)
   );

   ttodc_digits u_digits (
      .hours     (result.hours),
      .minutes   (result.minutes),
      .seconds   (result.seconds),
      .time_text (time_text)
   );

   // pack the result beat, lowest field first
   assign out_data_in = {3'b000,
                         result.switch_request,
                         result.second_rolled,
                         time_text,
                         result.subsecond,
                         result.seconds,
                         result.minutes,
                         result.hours};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: capture on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= ttodc_pkg::kind_type'(req_tuser);
         in_slice_ff <= req_tdata;
      end
      if (step_en)
         out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tick_time_of_day_clock_core: streams tick and slice-load beats,
// predicts every result beat from its own copy of the clock state and compares field by
// field. Depends on ttodc_pkg and the core itself.

module tb_top;

   localparam int unsigned MAX_REPORTED = 10;
   localparam int unsigned RSP_WIDTH = 80;

   // One predicted result beat, field for field as the core packs rsp_tdata
   typedef struct {
      logic [ttodc_pkg::HOUR_WIDTH-1:0]   hours;
      logic [ttodc_pkg::MINUTE_WIDTH-1:0] minutes;
      logic [ttodc_pkg::SECOND_WIDTH-1:0] seconds;
      logic [ttodc_pkg::TICK_WIDTH-1:0]   subsecond;
      logic [ttodc_pkg::TEXT_WIDTH-1:0]   time_text;
      logic                               second_rolled;
      logic                               switch_request;
   } clock_reading_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;   // [15:0] slice_count
   logic                 req_tuser = 1'b0; // [0] kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [4:0] hours, [10:5] minutes, [16:11] seconds, [26:17] subsecond,
   // [74:27] time_text, [75] second_rolled, [76] switch_request, [79:77] zero
   logic [RSP_WIDTH-1:0] rsp_tdata;

   // Independent copy of the time keeper and the slice countdown
   logic [ttodc_pkg::TICK_WIDTH-1:0]   tod_tick;
   logic [ttodc_pkg::SECOND_WIDTH-1:0] tod_second;
   logic [ttodc_pkg::MINUTE_WIDTH-1:0] tod_minute;
   logic [ttodc_pkg::HOUR_WIDTH-1:0]   tod_hour;
   logic [ttodc_pkg::SLICE_WIDTH-1:0]  slice_left;
   logic                               switching_armed;

   clock_reading_type expected_readings[$];

   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;

   int unsigned mismatch_count = 0;
   int unsigned readings_checked = 0;
   int unsigned ticks_sent = 0;
   int unsigned loads_sent = 0;
   int unsigned seconds_rolled = 0;
   int unsigned minutes_rolled = 0;
   int unsigned switch_requests = 0;

   tick_time_of_day_clock_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop: generous against the length of a correct run
   initial begin
      #1_000_000;
      $display("Timeout: %0d readings still outstanding", expected_readings.size());
      $display("Test completed with failures");
      $finish;
   end

   // ASCII tens and units of a counter value
   function automatic logic [15:0] ascii_pair(input int unsigned value);
      logic [7:0] tens;
      logic [7:0] units;
      tens = ttodc_pkg::ASCII_ZERO + 8'((value / 10) % 10);
      units = ttodc_pkg::ASCII_ZERO + 8'(value % 10);
      return {tens, units};
   endfunction

   function automatic void clear_time_of_day();
      tod_tick = '0;
      tod_second = '0;
      tod_minute = '0;
      tod_hour = '0;
      slice_left = '0;
      switching_armed = 1'b0;
   endfunction

   // Apply one accepted beat to the predicted state and return the reading it yields
   function automatic clock_reading_type advance_time_of_day(
         input ttodc_pkg::kind_type kind,
         input logic [ttodc_pkg::SLICE_WIDTH-1:0] slice);
      clock_reading_type reading;
      int unsigned       next_tick;
      reading.second_rolled = 1'b0;
      reading.switch_request = 1'b0;
      if (kind == ttodc_pkg::KIND_LOAD) begin
         // a load re-arms the countdown and leaves the time alone
         slice_left = slice;
         switching_armed = 1'b1;
      end else begin
         next_tick = (32'(tod_tick) + 1) & 32'h7FF;
         if (next_tick >= ttodc_pkg::TICKS_PER_SECOND) begin
            next_tick = 0;
            reading.second_rolled = 1'b1;
            seconds_rolled++;
            if (32'(tod_second) + 1 >= ttodc_pkg::SECONDS_PER_MINUTE) begin
               tod_second = '0;
               minutes_rolled++;
               if (32'(tod_minute) + 1 >= ttodc_pkg::MINUTES_PER_HOUR) begin
                  tod_minute = '0;
                  if (32'(tod_hour) + 1 >= ttodc_pkg::HOURS_PER_DAY) tod_hour = '0;
                  else tod_hour = tod_hour + 1'b1;
               end else begin
                  tod_minute = tod_minute + 1'b1;
               end
            end else begin
               tod_second = tod_second + 1'b1;
            end
         end
         tod_tick = ttodc_pkg::TICK_WIDTH'(next_tick);
         // an armed countdown stuck at zero keeps requesting until the next load
         if (switching_armed) begin
            if (slice_left != '0) begin
               slice_left = slice_left - 1'b1;
            end else begin
               reading.switch_request = 1'b1;
               switch_requests++;
            end
         end
      end
      reading.hours = tod_hour;
      reading.minutes = tod_minute;
      reading.seconds = tod_second;
      reading.subsecond = tod_tick;
      reading.time_text = {ascii_pair(32'(tod_hour)), ascii_pair(32'(tod_minute)),
                           ascii_pair(32'(tod_second))};
      return reading;
   endfunction

   // Present one beat from a falling edge, hold it until accepted, then predict it
   task automatic send_beat(input ttodc_pkg::kind_type kind,
                            input logic [ttodc_pkg::SLICE_WIDTH-1:0] slice);
      clock_reading_type reading;
      while (sender_idles && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= slice;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reading = advance_time_of_day(kind, slice);
      expected_readings.push_back(reading);
      if (kind == ttodc_pkg::KIND_LOAD) loads_sent++;
      else ticks_sent++;
      @(negedge clock);
   endtask

   // Mostly short slices so the countdown expires often, now and then any 16-bit value
   function automatic logic [ttodc_pkg::SLICE_WIDTH-1:0] pick_slice();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) return ttodc_pkg::SLICE_WIDTH'($urandom_range(8));
      if (roll < 70) return ttodc_pkg::SLICE_WIDTH'($urandom_range(64));
      return ttodc_pkg::SLICE_WIDTH'($urandom);
   endfunction

   function automatic void compare_field(input string field,
                                         input logic [ttodc_pkg::TEXT_WIDTH-1:0] want,
                                         input logic [ttodc_pkg::TEXT_WIDTH-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   // Take the oldest reading and check every field of the beat against it
   task automatic check_reading(input logic [RSP_WIDTH-1:0] beat);
      clock_reading_type want;
      if (expected_readings.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("%0t: result beat with nothing expected, got %0h", $time, beat);
         return;
      end
      want = expected_readings.pop_front();
      readings_checked++;
      compare_field("hours", ttodc_pkg::TEXT_WIDTH'(want.hours),
                    ttodc_pkg::TEXT_WIDTH'(beat[4:0]));
      compare_field("minutes", ttodc_pkg::TEXT_WIDTH'(want.minutes),
                    ttodc_pkg::TEXT_WIDTH'(beat[10:5]));
      compare_field("seconds", ttodc_pkg::TEXT_WIDTH'(want.seconds),
                    ttodc_pkg::TEXT_WIDTH'(beat[16:11]));
      compare_field("subsecond", ttodc_pkg::TEXT_WIDTH'(want.subsecond),
                    ttodc_pkg::TEXT_WIDTH'(beat[26:17]));
      compare_field("time_text", want.time_text, beat[74:27]);
      compare_field("second_rolled", ttodc_pkg::TEXT_WIDTH'(want.second_rolled),
                    ttodc_pkg::TEXT_WIDTH'(beat[75]));
      compare_field("switch_request", ttodc_pkg::TEXT_WIDTH'(want.switch_request),
                    ttodc_pkg::TEXT_WIDTH'(beat[76]));
      compare_field("padding", '0, ttodc_pkg::TEXT_WIDTH'(beat[79:77]));
   endtask

   // Sample result beats on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
   end

   // Stall the result side at random from the falling edge
   always @(negedge clock) begin
      rsp_tready <= !(receiver_stalls && $urandom_range(99) < 8);
   end

   // Countdown corners: unarmed ticks, arming at zero, reloads, extreme slice values
   task automatic test_countdown_directed();
      send_beat(ttodc_pkg::KIND_TICK, 16'hFFFF);   // slice field ignored on a tick, unarmed
      send_beat(ttodc_pkg::KIND_TICK, 16'h0000);
      send_beat(ttodc_pkg::KIND_LOAD, 16'h0000);   // armed at zero: next tick requests
      send_beat(ttodc_pkg::KIND_TICK, 16'h5555);
      send_beat(ttodc_pkg::KIND_TICK, 16'hAAAA);   // left at zero, so requests again
      send_beat(ttodc_pkg::KIND_LOAD, 16'h0002);
      repeat (3) send_beat(ttodc_pkg::KIND_TICK, 16'h0000);
      send_beat(ttodc_pkg::KIND_LOAD, 16'hFFFF);   // longest slice
      repeat (2) send_beat(ttodc_pkg::KIND_TICK, 16'hFFFF);
      send_beat(ttodc_pkg::KIND_LOAD, 16'h0001);
      send_beat(ttodc_pkg::KIND_LOAD, 16'h0003);   // reload before expiry
      repeat (5) send_beat(ttodc_pkg::KIND_TICK, 16'h00FF);
      send_beat(ttodc_pkg::KIND_LOAD, 16'h8000);
      send_beat(ttodc_pkg::KIND_LOAD, 16'h7FFF);
      send_beat(ttodc_pkg::KIND_TICK, 16'hFF00);
   endtask

   // Random mix of ticks and loads, with a stretch of back-to-back traffic
   task automatic test_random_mix(input int unsigned beats);
      for (int unsigned i = 0; i < beats; i++) begin
         if (i == 600) begin
            sender_idles = 1'b0;
            receiver_stalls = 1'b0;
         end
         if (i == 900) begin
            sender_idles = 1'b1;
            receiver_stalls = 1'b1;
         end
         if ($urandom_range(99) < 20) send_beat(ttodc_pkg::KIND_LOAD, pick_slice());
         else send_beat(ttodc_pkg::KIND_TICK, ttodc_pkg::SLICE_WIDTH'($urandom));
      end
   endtask

   initial begin
      clear_time_of_day();
      // hold reset on rising edges, release on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_countdown_directed();
      test_random_mix(1600);
      req_tvalid <= 1'b0;
      // drain, then allow the two-stage pipeline time to show any stray beat
      wait (expected_readings.size() == 0);
      repeat (10) @(posedge clock);
      $display("Checked %0d readings: %0d ticks, %0d slice loads, %0d switch requests",
               readings_checked, ticks_sent, loads_sent, switch_requests);
      $display("Clock crossed %0d second and %0d minute boundaries, %0d mismatches",
               seconds_rolled, minutes_rolled, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
